>>> hdl/ltc_pkg.sv
`default_nettype none

package ltc_pkg;

   // Defaults for the top-level parameters
   localparam int NUM_STATES_DEF = 256;
   localparam int MAX_LAG_DEF    = 64;
   localparam int COUNT_BITS_DEF = 32;

   // Fixed field widths
   localparam int LAG_W       = 7;
   localparam int LABEL_W     = 8;
   localparam int CNT_OUT_W   = 32;
   localparam int REQ_TDATA_W = 2 * LABEL_W;
   localparam int RSP_TDATA_W = CNT_OUT_W + 2 * LABEL_W;

   localparam logic [LAG_W-1:0] LAG_RESET = 7'd1;

   // Controller to datapath commands
   typedef struct packed {
      logic clear_wr;
      logic capture;
      logic hist_rd;
      logic cell_rd;
      logic commit;
      logic load_out;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } sts_type;

   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

`default_nettype wire

>>> hdl/lagged_transition_counter.sv
// Lagged transition counter. Each request transaction is either a frame label
// (req_tuser = 0) or a cell read (req_tuser = 1). A frame label is stored in a
// ring of the last MAX_LAG labels; when at least lag_steps earlier frames of
// the same chunk exist, the count cell (label lag_steps back, this label) is
// incremented with saturation and returned. req_tlast marks the last frame of
// a chunk, after which counting restarts. A read returns the addressed cell
// without touching any state. Every request yields exactly one response.
// Timing: accept, ring read, count read and count write-back, one transaction
// at a time; the write-back waits while the response side stalls a previous
// result. The single-port-per-direction count memory and its registered read
// set this. After reset the count memory is swept to zero, one cell per cycle,
// over NUM_STATES rounded up to a power of two, squared, cells (65536 with the
// defaults); req_tready stays low during the sweep. The user must write lag_steps
// through csr_wr_en / csr_wr_data while idle; the block does not enforce it.
`default_nettype none

module lagged_transition_counter #(
   parameter int NUM_STATES = ltc_pkg::NUM_STATES_DEF,
   parameter int MAX_LAG    = ltc_pkg::MAX_LAG_DEF,
   parameter int COUNT_BITS = ltc_pkg::COUNT_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request channel
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [ltc_pkg::REQ_TDATA_W-1:0]  req_tdata,  // state_label, read_target
   input  wire logic                             req_tuser,  // mode
   input  wire logic                             req_tlast,  // chunk_end
   // Response channel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [ltc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // cell_count, pair_origin, pair_dest
   output logic                                  rsp_tuser,  // pair_counted
   // Configuration: lag_steps
   input  wire logic                             csr_wr_en,
   input  wire logic [ltc_pkg::LAG_W-1:0]        csr_wr_data
);

   ltc_pkg::cmd_type cmd;
   ltc_pkg::sts_type sts;

   // Sequence one transaction at a time and run the reset sweep
   ltc_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Hold the ring, chunk count, count memory and response register
   ltc_datapath #(
      .NUM_STATES (NUM_STATES),
      .MAX_LAG    (MAX_LAG),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

>>> hdl/ltc_ram.sv
`default_nettype none

module ltc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [ltc_pkg::addr_bits(DEPTH)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [ltc_pkg::addr_bits(DEPTH)-1:0]  rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/ltc_datapath.sv
`default_nettype none

module ltc_datapath #(
   parameter int NUM_STATES = ltc_pkg::NUM_STATES_DEF,
   parameter int MAX_LAG    = ltc_pkg::MAX_LAG_DEF,
   parameter int COUNT_BITS = ltc_pkg::COUNT_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire ltc_pkg::cmd_type                   cmd,
   output ltc_pkg::sts_type                        sts,
   input  wire logic [ltc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire logic                               req_tuser,
   input  wire logic                               req_tlast,
   input  wire logic                               csr_wr_en,
   input  wire logic [ltc_pkg::LAG_W-1:0]          csr_wr_data,
   input  wire logic                               rsp_tready,
   output logic                                    rsp_tvalid,
   output logic      [ltc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                    rsp_tuser
);

   localparam int LW     = ltc_pkg::LABEL_W;
   localparam int GW     = ltc_pkg::LAG_W;
   localparam int ST_W   = ltc_pkg::addr_bits(NUM_STATES);
   localparam int CELL_W = 2 * ST_W;
   localparam int CELL_N = 1 << CELL_W;
   localparam int HP_W   = ltc_pkg::addr_bits(MAX_LAG);
   localparam int CF_W   = $clog2(MAX_LAG + 1);
   localparam int DIFF_W = ((HP_W > GW) ? HP_W : GW) + 2;

   // Configuration and captured transaction
   logic [GW-1:0]    lag_ff, lag_in;
   logic             mode_ff, last_ff;
   logic [LW-1:0]    label_ff, target_ff;

   // Ring and chunk tracking
   logic [HP_W-1:0]  ptr_ff, ptr_in;
   logic [CF_W-1:0]  chunk_ff, chunk_in;
   logic             pair_ok_ff;

   // Cell lookup results
   logic             counted_ff, rd_ok_ff;
   logic [LW-1:0]    origin_ff, dest_ff;
   logic [CELL_W-1:0] cell_ff;

   // Clearing sweep
   logic [CELL_W-1:0] clr_addr_ff;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ltc_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic             rsp_user_ff;

   logic                      lag_ok;
   logic signed [DIFF_W-1:0]  slot_diff, slot_wrap;
   logic [HP_W-1:0]           slot_addr;
   logic [LW-1:0]             from_label;
   logic                      from_ok, lab_ok, tgt_ok, counted_in;
   logic [CELL_W-1:0]         cell_rd_addr;
   logic [COUNT_BITS-1:0]     cnt_rd_data, cnt_sat, cnt_result;
   logic                      cnt_wr_en;
   logic [CELL_W-1:0]         cnt_wr_addr;
   logic [COUNT_BITS-1:0]     cnt_wr_data;

   // Ring slot lag frames behind the write pointer
   assign lag_ok = (lag_ff != '0) && (32'(lag_ff) <= MAX_LAG)
                   && (32'(chunk_ff) >= 32'(lag_ff));
   assign slot_diff = $signed(DIFF_W'(ptr_ff)) - $signed(DIFF_W'(lag_ff));
   assign slot_wrap = slot_diff + $signed(DIFF_W'(MAX_LAG));
   assign slot_addr = (slot_diff < 0) ? HP_W'(slot_wrap) : HP_W'(slot_diff);

   assign from_ok = 32'(from_label) < NUM_STATES;
   assign lab_ok  = 32'(label_ff)   < NUM_STATES;
   assign tgt_ok  = 32'(target_ff)  < NUM_STATES;
   assign counted_in = !mode_ff && pair_ok_ff && from_ok && lab_ok;
   assign cell_rd_addr = mode_ff ? {ST_W'(label_ff), ST_W'(target_ff)}
                                 : {ST_W'(from_label), ST_W'(label_ff)};

   assign cnt_sat    = (&cnt_rd_data) ? cnt_rd_data : cnt_rd_data + 1'b1;
   assign cnt_result = counted_ff ? cnt_sat : (rd_ok_ff ? cnt_rd_data : '0);

   assign cnt_wr_en   = cmd.clear_wr || (cmd.load_out && counted_ff);
   assign cnt_wr_addr = cmd.clear_wr ? clr_addr_ff : cell_ff;
   assign cnt_wr_data = cmd.clear_wr ? '0 : cnt_sat;

   always_comb begin
      lag_in = lag_ff;
      if (csr_wr_en) begin
         lag_in = csr_wr_data;
      end
      ptr_in   = ptr_ff;
      chunk_in = chunk_ff;
      if (cmd.commit && !mode_ff) begin
         ptr_in = (32'(ptr_ff) == MAX_LAG - 1) ? '0 : ptr_ff + 1'b1;
         if (last_ff) begin
            chunk_in = '0;
         end else if (32'(chunk_ff) < MAX_LAG) begin
            chunk_in = chunk_ff + 1'b1;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lag_ff       <= ltc_pkg::LAG_RESET;
         ptr_ff       <= '0;
         chunk_ff     <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lag_ff       <= lag_in;
         ptr_ff       <= ptr_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clear_wr) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff   <= req_tuser;
         last_ff   <= req_tlast;
         label_ff  <= req_tdata[LW-1:0];
         target_ff <= req_tdata[2*LW-1:LW];
      end
      if (cmd.hist_rd) begin
         pair_ok_ff <= lag_ok;
      end
      if (cmd.cell_rd) begin
         counted_ff <= counted_in;
         rd_ok_ff   <= mode_ff && lab_ok && tgt_ok;
         cell_ff    <= cell_rd_addr;
         origin_ff  <= mode_ff ? label_ff  : (counted_in ? from_label : '0);
         dest_ff    <= mode_ff ? target_ff : (counted_in ? label_ff   : '0);
      end
      if (cmd.load_out) begin
         rsp_data_ff <= {dest_ff, origin_ff, ltc_pkg::CNT_OUT_W'(cnt_result)};
         rsp_user_ff <= counted_ff;
      end
   end

   ltc_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_LAG)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && !mode_ff),
      .wr_addr (ptr_ff),
      .wr_data (label_ff),
      .rd_en   (cmd.hist_rd),
      .rd_addr (slot_addr),
      .rd_data (from_label)
   );

   ltc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (CELL_N)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cmd.cell_rd),
      .rd_addr (cell_rd_addr),
      .rd_data (cnt_rd_data)
   );

   assign sts.clear_last = &clr_addr_ff;
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

>>> hdl/ltc_controller.sv
`default_nettype none

module ltc_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output ltc_pkg::cmd_type       cmd,
   input  wire ltc_pkg::sts_type  sts
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HIST,
      ST_CELL,
      ST_UPD
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_HIST;
            end
         end
         ST_HIST: begin
            cmd.hist_rd = 1'b1;
            state_in    = ST_CELL;
         end
         ST_CELL: begin
            cmd.cell_rd = 1'b1;
            cmd.commit  = 1'b1;
            state_in    = ST_UPD;
         end
         ST_UPD: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/ltc_checker.sv
`default_nettype none

module ltc_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [ltc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire logic                             rsp_tuser
);

   // Reset starts the clearing sweep: no request taken right after it
   a_sweep_blocks: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request accepted while count memory is being cleared");

   a_no_stale_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // One transaction at a time: accept closes the request side from the next cycle on
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request accepted while one is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser)))
      else $error("stalled response changed or dropped");

endmodule

bind lagged_transition_counter ltc_checker u_checker (.*);

`default_nettype wire

>>> bench/lagged_transition_counter_tb.sv
module lagged_transition_counter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LAG     = ltc_pkg::MAX_LAG_DEF;
   localparam int CYCLE_LIMIT = 500000;   // clearing sweep plus slow traffic, with margin
   localparam int HOLD_CYCLES = 300;      // long response stall, enough to back up the request side
   localparam int NUM_PHASES  = 10;

   // Lag settings per random phase: out-of-range values (0, 65, 127) count nothing,
   // 64 is the deepest ring reach, 1 the shortest.
   localparam int LAG_PLAN [NUM_PHASES] = '{0, 5, 64, 127, 2, 65, 1, 17, 3, 33};

   // One request transaction as the stimulus sees it
   typedef struct packed {
      logic                         is_read;
      logic [ltc_pkg::LABEL_W-1:0]  label;
      logic [ltc_pkg::LABEL_W-1:0]  target;
      logic                         chunk_end;
   } frame_item_type;

   // One response transaction, field by field
   typedef struct packed {
      logic [ltc_pkg::CNT_OUT_W-1:0] cell_count;
      logic                          pair_counted;
      logic [ltc_pkg::LABEL_W-1:0]   pair_origin;
      logic [ltc_pkg::LABEL_W-1:0]   pair_dest;
   } transition_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [ltc_pkg::REQ_TDATA_W-1:0]  req_tdata = '0;   // state_label, read_target
   logic                             req_tuser = 1'b0; // mode
   logic                             req_tlast = 1'b0; // chunk_end
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [ltc_pkg::RSP_TDATA_W-1:0]  rsp_tdata;        // cell_count, pair_origin, pair_dest
   logic                             rsp_tuser;        // pair_counted
   logic                             csr_wr_en = 1'b0;
   logic [ltc_pkg::LAG_W-1:0]        csr_wr_data = '0;

   lagged_transition_counter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor state: lag register, label ring, chunk frame count, count matrix
   logic [ltc_pkg::LAG_W-1:0]      lag_now = ltc_pkg::LAG_RESET;
   logic [ltc_pkg::LABEL_W-1:0]    recent_labels [MAX_LAG];
   logic [5:0]                     ring_slot = '0;
   logic [6:0]                     frames_in_chunk = '0;
   bit   [ltc_pkg::CNT_OUT_W-1:0]  tally [0:65535];

   frame_item_type         frames_to_send [$];
   transition_result_type  expected_tallies [$];
   logic [15:0]            seen_cells [$];   // cells that got counted, to aim reads at

   int queued_count   = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int req_idle_pct   = 0;
   int rsp_idle_pct   = 0;
   int hold_orders    = 0;
   int holds_served   = 0;
   int hold_left      = 0;
   logic req_fire     = 1'b0;   // request transaction completed at the last rising edge

   initial begin
      forever #6 clock = ~clock;
   end

   // Count one transaction through the predictor and return the response it must produce.
   function automatic transition_result_type tally_step(input frame_item_type item);
      transition_result_type        r;
      logic [5:0]                   back_slot;
      logic [ltc_pkg::LABEL_W-1:0]  origin;
      logic [15:0]                  cell_idx;
      r = '0;
      if (item.is_read) begin
         // Read: echo the address, leave every piece of state alone
         r.cell_count  = tally[{item.label, item.target}];
         r.pair_origin = item.label;
         r.pair_dest   = item.target;
      end else begin
         if (lag_now >= 1 && lag_now <= MAX_LAG && frames_in_chunk >= lag_now) begin
            // Reach lag_now frames back; the 6-bit difference wraps around the ring
            back_slot = ring_slot - lag_now[5:0];
            origin    = recent_labels[back_slot];
            cell_idx  = {origin, item.label};
            if (tally[cell_idx] != '1)
               tally[cell_idx] = tally[cell_idx] + 1'b1;
            r.cell_count   = tally[cell_idx];
            r.pair_counted = 1'b1;
            r.pair_origin  = origin;
            r.pair_dest    = item.label;
            if (seen_cells.size() < 512)
               seen_cells.insert(seen_cells.size(), cell_idx);
         end
         recent_labels[ring_slot] = item.label;
         ring_slot = ring_slot + 1'b1;
         // Restart the chunk after its last frame, otherwise count up to the ring depth
         if (item.chunk_end)
            frames_in_chunk = '0;
         else if (frames_in_chunk < MAX_LAG)
            frames_in_chunk = frames_in_chunk + 1'b1;
      end
      return r;
   endfunction

   task automatic push_request(input logic is_read, input logic [7:0] label,
                               input logic [7:0] target, input logic chunk_end);
      frames_to_send.insert(frames_to_send.size(),
                            frame_item_type'{is_read, label, target, chunk_end});
      queued_count++;
   endtask

   // Block until every queued transaction is accepted and every response has arrived.
   task automatic wait_for_drain;
      do @(negedge clock);
      while (accepted_count != queued_count || expected_tallies.size() != 0);
   endtask

   // Request driver: present a new transaction once the last one completed, or idle
   always @(negedge clock) begin
      frame_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (frames_to_send.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            nxt = frames_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {nxt.target, nxt.label};
            req_tuser  <= nxt.is_read;
            req_tlast  <= nxt.chunk_end;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response ready: honor a long hold when one is ordered, otherwise stall at random
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_served != hold_orders) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Monitor: check responses against the oldest expectation, then predict new requests.
   // Check before predicting so a response and a new request on the same edge stay in order.
   always @(posedge clock) begin
      transition_result_type want;
      transition_result_type got;
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[31:0], rsp_tuser, rsp_tdata[39:32], rsp_tdata[47:40]};
            if (expected_tallies.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response count=%0d counted=%0b origin=%0d dest=%0d",
                        $realtime, got.cell_count, got.pair_counted, got.pair_origin,
                        got.pair_dest);
            end else begin
               want = expected_tallies.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  $display("%0t: response mismatch", $realtime);
                  $display("   expected count=%0d counted=%0b origin=%0d dest=%0d",
                           want.cell_count, want.pair_counted, want.pair_origin,
                           want.pair_dest);
                  $display("   actual   count=%0d counted=%0b origin=%0d dest=%0d",
                           got.cell_count, got.pair_counted, got.pair_origin, got.pair_dest);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_tallies.insert(expected_tallies.size(),
                                    tally_step({req_tuser, req_tdata[7:0],
                                                req_tdata[15:8], req_tlast}));
            accepted_count++;
         end
         if (csr_wr_en)
            lag_now = csr_wr_data;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("lagged_transition_counter_tb: done, errors");
         $finish;
      end
   end

   // Stimulus: reset, a directed pass at the reset lag, then random phases per lag setting
   initial begin
      int lag;
      int n_items;
      int made;
      int frames_left;
      int palette_base;
      logic [15:0] pick_cell;
      logic [7:0] label;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // First idling pattern: sender idles more rarely than the receiver
      req_idle_pct = 31;
      rsp_idle_pct = 46;

      // Directed pass, lag 1. Extremes of the labels, a chunk end, reads of hit and empty
      // cells; read_target in frame mode and tlast in read mode must be ignored.
      push_request(1'b0, 8'h00, 8'hFF, 1'b0);  // first frame of chunk: no pair
      push_request(1'b0, 8'hFF, 8'h00, 1'b0);  // count 0 -> 255
      push_request(1'b0, 8'hFF, 8'hAA, 1'b0);  // count 255 -> 255
      push_request(1'b0, 8'h00, 8'h55, 1'b1);  // count 255 -> 0, then close the chunk
      push_request(1'b0, 8'h55, 8'h00, 1'b0);  // new chunk: nothing crosses the boundary
      push_request(1'b0, 8'hAA, 8'hFF, 1'b0);  // count 0x55 -> 0xAA
      push_request(1'b0, 8'hAA, 8'h00, 1'b1);  // count 0xAA -> 0xAA, close the chunk
      push_request(1'b1, 8'h00, 8'hFF, 1'b1);  // read with tlast set
      push_request(1'b1, 8'hFF, 8'hFF, 1'b0);
      push_request(1'b1, 8'hFF, 8'h00, 1'b0);
      push_request(1'b1, 8'h55, 8'hAA, 1'b0);
      push_request(1'b1, 8'hAA, 8'h55, 1'b0);  // never counted: reads zero
      push_request(1'b1, 8'h00, 8'h00, 1'b1);
      push_request(1'b0, 8'hAA, 8'h55, 1'b0);  // read did not disturb the chunk: no pair
      push_request(1'b0, 8'hAA, 8'hFF, 1'b0);  // second hit on 0xAA -> 0xAA
      push_request(1'b1, 8'hAA, 8'hAA, 1'b0);
      push_request(1'b0, 8'h7F, 8'h80, 1'b1);
      wait_for_drain;

      for (int p = 0; p < NUM_PHASES; p++) begin
         // Let the last response leave the pipeline before touching the lag register
         repeat (6) @(negedge clock);
         lag = LAG_PLAN[p];
         if (p >= 7) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else if (p >= 4) begin
            req_idle_pct = 46;
            rsp_idle_pct = 31;
         end
         csr_wr_en   <= 1'b1;
         csr_wr_data <= lag[ltc_pkg::LAG_W-1:0];
         @(negedge clock);
         csr_wr_en   <= 1'b0;

         // Stall the response side for a long stretch while requests keep coming
         if (p == 2)
            hold_orders++;

         n_items      = 50 + ((lag >= 1 && lag <= MAX_LAG) ? lag : 0);
         palette_base = $urandom_range(250);
         frames_left  = 0;
         made         = 0;
         while (made < n_items) begin
            if ($urandom_range(99) < 12) begin
               // Read: aim at counted cells half the time, anywhere otherwise
               if (seen_cells.size() != 0 && $urandom_range(1) == 0)
                  pick_cell = seen_cells[$urandom_range(seen_cells.size() - 1)];
               else
                  pick_cell = 16'($urandom_range(16'hFFFF));
               push_request(1'b1, pick_cell[15:8], pick_cell[7:0], 1'($urandom_range(1)));
            end else begin
               // Chunks mostly long enough to exceed the lag, some very short
               if (frames_left == 0)
                  frames_left = ($urandom_range(9) == 0) ? $urandom_range(1, 3)
                              : $urandom_range(1, 2 * ((lag >= 1 && lag <= MAX_LAG) ? lag : 8)
                                                  + 8);
               // Small label palette so cells are hit repeatedly, full range now and then
               if ($urandom_range(3) == 0)
                  label = 8'($urandom_range(255));
               else
                  label = 8'(palette_base + $urandom_range(5));
               push_request(1'b0, label, 8'($urandom_range(255)), frames_left == 1);
               frames_left--;
            end
            made++;
         end
         wait_for_drain;
      end

      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && expected_tallies.size() == 0)
         $display("lagged_transition_counter_tb: done, clean");
      else
         $display("lagged_transition_counter_tb: done, errors");
      $finish;
   end

endmodule
